// ----- sv/srr_pkg.sv -----
// srr_pkg: shared types and codes of the selective-repeat receiver
// no dependencies; imported by srr_front, srr_engine and the top level

package srr_pkg;

   typedef enum logic [1:0] {
      CMD_DATA = 2'd0,
      CMD_REQ  = 2'd1,
      CMD_FIN  = 2'd2,
      CMD_CLS  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_REQ_ACK = 3'd0,
      KIND_FIN_ACK = 3'd1,
      KIND_ACK     = 3'd2,
      KIND_DELIVER = 3'd3,
      KIND_END     = 3'd4
   } kind_type;

   localparam int SEQ_W = 5;
   localparam int LEN_W = 11;
   localparam int REF_W = 32;
   localparam int WIN_W = 5;
   localparam logic [WIN_W-1:0] WIN_RESET = 5'd4;

   // decoded datagram, front part to engine
   typedef struct packed {
      cmd_type          cmd;
      logic [SEQ_W-1:0] seq_id;
      logic [LEN_W-1:0] len;
      logic [REF_W-1:0] pref;
   } srr_item_type;

   // one result word
   typedef struct packed {
      kind_type         kind;
      logic [SEQ_W-1:0] ack_seq;
      logic [LEN_W-1:0] out_len;
      logic [REF_W-1:0] out_ref;
      logic             last;
   } srr_result_type;

endpackage

// ----- sv/selective_repeat_receiver_reorder.sv -----
// Selective-repeat receiver with in-order delivery. Datagrams enter a two-entry
// queue after decode; one sequencer in srr_engine then works on one datagram at a
// time and pushes its results into a two-entry result queue. Each payload that a data
// datagram delivers from the slot store takes a registered read, then the delivery.
// After a window_size change the first data datagram first folds the window base into
// the new sequence space, one subtraction per cycle. Slot valid bits are cleared at
// reset at once; there is no clearing pass. window_size may be written only while no
// datagram is in flight.
// depends on srr_pkg, srr_front, srr_engine and srr_fifo

module selective_repeat_receiver_reorder import srr_pkg::*; #(
   parameter int MAX_WINDOW    = 16,
   parameter int PAYLOAD_BYTES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic [WIN_W-1:0] csr_write_data,
   input  logic             push,
   output logic             full,
   input  logic [1:0]       req_cmd,
   input  logic [SEQ_W-1:0] req_seq_id,
   input  logic [LEN_W-1:0] req_payload_len,
   input  logic [REF_W-1:0] req_payload_ref,
   output logic             empty,
   input  logic             pop,
   output logic [2:0]       rsp_kind,
   output logic [SEQ_W-1:0] rsp_ack_seq,
   output logic [LEN_W-1:0] rsp_out_len,
   output logic [REF_W-1:0] rsp_out_ref,
   output logic             rsp_last
);

   logic           item_valid;
   logic           item_pop;
   srr_item_type   item;
   logic           res_push;
   logic           res_full;
   srr_result_type res;
   srr_result_type res_q;

   srr_front #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (push),
      .req_cmd         (req_cmd),
      .req_seq_id      (req_seq_id),
      .req_payload_len (req_payload_len),
      .req_payload_ref (req_payload_ref),
      .req_full        (full),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop)
   );

   srr_engine #(
      .MAX_WINDOW(MAX_WINDOW)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop),
      .res_push       (res_push),
      .res            (res),
      .res_full       (res_full)
   );

   srr_fifo #(
      .WIDTH($bits(srr_result_type))
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   (res),
      .full  (res_full),
      .pop   (pop),
      .dout  (res_q),
      .empty (empty)
   );

   assign rsp_kind    = res_q.kind;
   assign rsp_ack_seq = res_q.ack_seq;
   assign rsp_out_len = res_q.out_len;
   assign rsp_out_ref = res_q.out_ref;
   assign rsp_last    = res_q.last;

endmodule

// ----- sv/srr_fifo.sv -----
// srr_fifo: two-entry queue of generic width
// no dependencies; used between front and engine and on the result side

module srr_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic [1:0]       count_ff, count_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign dout    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ----- sv/srr_front.sv -----
// srr_front: accepts datagrams, decodes the command and clamps the length
// depends on srr_pkg and srr_fifo

module srr_front import srr_pkg::*; #(
   parameter int PAYLOAD_BYTES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic [1:0]         req_cmd,
   input  logic [SEQ_W-1:0]   req_seq_id,
   input  logic [LEN_W-1:0]   req_payload_len,
   input  logic [REF_W-1:0]   req_payload_ref,
   output logic               req_full,
   output logic               item_valid,
   output srr_item_type       item,
   input  logic               item_pop
);

   srr_item_type item_d;
   logic         item_empty;
   logic         too_long;

   // compare at 17 bits so any byte limit up to 131071 works
   assign too_long = {6'd0, req_payload_len} > 17'(PAYLOAD_BYTES);

   always_comb begin
      item_d.cmd    = cmd_type'(req_cmd);
      item_d.seq_id = req_seq_id;
      item_d.len    = too_long ? LEN_W'(PAYLOAD_BYTES) : req_payload_len;
      item_d.pref   = req_payload_ref;
   end

   srr_fifo #(
      .WIDTH($bits(srr_item_type))
   ) u_item_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .din   (item_d),
      .full  (req_full),
      .pop   (item_pop),
      .dout  (item),
      .empty (item_empty)
   );

   assign item_valid = !item_empty;

endmodule

// ----- sv/srr_engine.sv -----
// srr_engine: session flags, receive window, slot store and in-order drain
// depends on srr_pkg

module srr_engine import srr_pkg::*; #(
   parameter int MAX_WINDOW = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic [WIN_W-1:0] csr_write_data,
   input  logic             item_valid,
   input  srr_item_type     item,
   output logic             item_pop,
   output logic             res_push,
   output srr_result_type   res,
   input  logic             res_full
);

   localparam int NSLOTS = 2 * MAX_WINDOW;
   localparam int SLOT_W = (NSLOTS > 2) ? $clog2(NSLOTS) : 1;
   localparam int AW     = (SLOT_W > 6) ? SLOT_W : 6;
   localparam int WCAP   = (MAX_WINDOW > 31) ? 31 : MAX_WINDOW;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_NORM,
      S_ACK,
      S_RD,
      S_DLV
   } state_type;

   state_type           state_ff, state_in;
   logic [WIN_W-1:0]    window_ff, window_in;
   logic                req_seen_ff, req_seen_in;
   logic                hs_done_ff, hs_done_in;
   logic                fin_seen_ff, fin_seen_in;
   logic                closed_ff, closed_in;
   logic [SLOT_W-1:0]   base_ff, base_in;
   logic [WIN_W-1:0]    cnt_ff, cnt_in;
   logic [NSLOTS-1:0]   valid_ff, valid_in;
   srr_item_type        item_ff, item_in;

   logic [LEN_W-1:0]    len_mem [NSLOTS];
   logic [REF_W-1:0]    ref_mem [NSLOTS];
   logic [LEN_W-1:0]    rd_len_ff;
   logic [REF_W-1:0]    rd_ref_ff;
   logic                mem_we;

   logic [WIN_W-1:0]    w;
   logic [AW-1:0]       space_a, base_a, seq_a, diff_a;
   logic                in_win;
   logic [SLOT_W-1:0]   seq_idx, next_base;
   logic                base_ready, cont;

   // effective window: zero acts as one, clamped at MAX_WINDOW (half the slots) and at 31
   always_comb begin
      if (window_ff == '0) begin
         w = WIN_W'(1);
      end else if (window_ff > WIN_W'(WCAP)) begin
         w = WIN_W'(WCAP);
      end else begin
         w = window_ff;
      end
   end

   assign space_a = AW'({w, 1'b0});
   assign base_a  = AW'(base_ff);
   assign seq_a   = AW'(item_ff.seq_id);
   assign seq_idx = SLOT_W'(item_ff.seq_id);
   assign diff_a  = (seq_a >= base_a) ? (seq_a - base_a) : (seq_a + space_a - base_a);
   assign in_win  = (seq_a < space_a) && (diff_a < AW'(w));

   // base slot holds a word now or gets one in this cycle
   assign base_ready = valid_ff[base_ff] || (seq_idx == base_ff);
   assign next_base  = ((base_a + AW'(1)) == space_a) ? '0 : SLOT_W'(base_a + AW'(1));
   assign cont       = ((AW'(cnt_ff) + AW'(1)) < AW'(w)) && valid_ff[next_base];

   always_comb begin
      state_in    = state_ff;
      window_in   = csr_write_en ? csr_write_data : window_ff;
      req_seen_in = req_seen_ff;
      hs_done_in  = hs_done_ff;
      fin_seen_in = fin_seen_ff;
      closed_in   = closed_ff;
      base_in     = base_ff;
      cnt_in      = cnt_ff;
      valid_in    = valid_ff;
      item_in     = item_ff;
      item_pop    = 1'b0;
      res_push    = 1'b0;
      res         = '0;
      mem_we      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               item_in  = item;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (closed_ff) begin
               state_in = S_IDLE;
            end else if (fin_seen_ff) begin
               // anything after FIN ends the session
               if (!res_full) begin
                  res_push  = 1'b1;
                  res.kind  = KIND_END;
                  res.last  = 1'b1;
                  closed_in = 1'b1;
                  state_in  = S_IDLE;
               end
            end else begin
               case (item_ff.cmd)
                  CMD_REQ: begin
                     if (hs_done_ff) begin
                        state_in = S_IDLE;
                     end else if (!res_full) begin
                        res_push    = 1'b1;
                        res.kind    = KIND_REQ_ACK;
                        res.last    = 1'b1;
                        req_seen_in = 1'b1;
                        state_in    = S_IDLE;
                     end
                  end
                  CMD_FIN: begin
                     if (!(req_seen_ff && hs_done_ff)) begin
                        state_in = S_IDLE;
                     end else if (!res_full) begin
                        res_push    = 1'b1;
                        res.kind    = KIND_FIN_ACK;
                        res.last    = 1'b1;
                        fin_seen_in = 1'b1;
                        state_in    = S_IDLE;
                     end
                  end
                  CMD_DATA: begin
                     state_in = req_seen_ff ? S_NORM : S_IDLE;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_NORM: begin
            // fold the base into the current sequence space, one subtract a cycle
            if (base_a >= space_a) begin
               base_in = SLOT_W'(base_a - space_a);
            end else begin
               state_in = S_ACK;
            end
         end
         S_ACK: begin
            if (!res_full) begin
               res_push    = 1'b1;
               res.kind    = KIND_ACK;
               res.ack_seq = item_ff.seq_id;
               res.last    = !(in_win && base_ready);
               state_in    = S_IDLE;
               if (in_win) begin
                  mem_we            = 1'b1;
                  valid_in[seq_idx] = 1'b1;
                  hs_done_in        = 1'b1;
                  cnt_in            = '0;
                  if (base_ready) begin
                     state_in = S_RD;
                  end
               end
            end
         end
         S_RD: begin
            state_in = S_DLV;
         end
         S_DLV: begin
            if (!res_full) begin
               res_push          = 1'b1;
               res.kind          = KIND_DELIVER;
               res.out_len       = rd_len_ff;
               res.out_ref       = rd_ref_ff;
               res.last          = !cont;
               valid_in[base_ff] = 1'b0;
               base_in           = next_base;
               cnt_in            = cnt_ff + WIN_W'(1);
               state_in          = cont ? S_RD : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         window_ff   <= WIN_RESET;
         req_seen_ff <= 1'b0;
         hs_done_ff  <= 1'b0;
         fin_seen_ff <= 1'b0;
         closed_ff   <= 1'b0;
         base_ff     <= '0;
         cnt_ff      <= '0;
         valid_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         window_ff   <= window_in;
         req_seen_ff <= req_seen_in;
         hs_done_ff  <= hs_done_in;
         fin_seen_ff <= fin_seen_in;
         closed_ff   <= closed_in;
         base_ff     <= base_in;
         cnt_ff      <= cnt_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // slot store: written at the arriving number, read at the window base
   always_ff @(posedge clock) begin
      if (mem_we) begin
         len_mem[seq_idx] <= item_ff.len;
         ref_mem[seq_idx] <= item_ff.pref;
      end
      rd_len_ff <= len_mem[base_ff];
      rd_ref_ff <= ref_mem[base_ff];
   end

   // a word is only handed on when the result queue has room
   assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result pushed into a full queue");

   // delivery only from a slot that holds a word
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DLV) |-> valid_ff[base_ff])
      else $error("delivery from an empty slot");

   // the drain never walks more than one window
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DLV) |-> (AW'(cnt_ff) < AW'(w)))
      else $error("drain ran past the window");

   // a closed session stays closed until reset
   assert property (@(posedge clock) disable iff (reset)
      closed_ff |=> closed_ff)
      else $error("closed session reopened");

endmodule

// ----- sim/srr_checker.sv -----
`timescale 1ns / 1ps
// srr_checker: watches the datagram, result and csr ports of the receiver, predicts
// every result word and compares it; depends on srr_pkg only

module srr_checker import srr_pkg::*; #(
   parameter int MAX_WINDOW    = 16,
   parameter int PAYLOAD_BYTES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_en,
   input  logic [WIN_W-1:0] csr_write_data,
   input  logic             push,
   input  logic             full,
   input  logic [1:0]       req_cmd,
   input  logic [SEQ_W-1:0] req_seq_id,
   input  logic [LEN_W-1:0] req_payload_len,
   input  logic [REF_W-1:0] req_payload_ref,
   input  logic             empty,
   input  logic             pop,
   input  logic [2:0]       rsp_kind,
   input  logic [SEQ_W-1:0] rsp_ack_seq,
   input  logic [LEN_W-1:0] rsp_out_len,
   input  logic [REF_W-1:0] rsp_out_ref,
   input  logic             rsp_last,
   output int               mismatch_count,
   output int               words_waiting
);

   localparam int SLOTS = 2 * MAX_WINDOW;

   // predicted receiver state
   logic [WIN_W-1:0] window_reg;
   logic             req_got;
   logic             shook;
   logic             fin_got;
   logic             ended;
   logic [SEQ_W-1:0] base_ptr;
   logic             slot_full   [SLOTS];
   logic [LEN_W-1:0] slot_bytes  [SLOTS];
   logic [REF_W-1:0] slot_handle [SLOTS];

   srr_result_type expected_words[$];
   srr_result_type got_word;
   srr_result_type want_word;

   task automatic report_mismatch(input string what);
      if (mismatch_count < 50)
         $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic srr_result_type result_word(input kind_type kind,
                                                  input logic [SEQ_W-1:0] seq,
                                                  input logic [LEN_W-1:0] len,
                                                  input logic [REF_W-1:0] pref);
      srr_result_type w;
      w.kind    = kind;
      w.ack_seq = seq;
      w.out_len = len;
      w.out_ref = pref;
      w.last    = 1'b0;
      return w;
   endfunction

   task automatic predict_datagram(input cmd_type cmd,
                                   input logic [SEQ_W-1:0] seq,
                                   input logic [LEN_W-1:0] len,
                                   input logic [REF_W-1:0] pref);
      srr_result_type words[$];
      int win, space, offset, n;
      if (ended)
         return;
      if (fin_got) begin
         // anything after FIN closes the session
         ended = 1'b1;
         words.push_back(result_word(KIND_END, '0, '0, '0));
      end else begin
         case (cmd)
            CMD_REQ: begin
               if (!shook) begin
                  req_got = 1'b1;
                  words.push_back(result_word(KIND_REQ_ACK, '0, '0, '0));
               end
            end
            CMD_FIN: begin
               if (req_got && shook) begin
                  fin_got = 1'b1;
                  words.push_back(result_word(KIND_FIN_ACK, '0, '0, '0));
               end
            end
            CMD_CLS: ;
            CMD_DATA: begin
               if (req_got) begin
                  win = (window_reg == 0) ? 1
                      : ((int'(window_reg) > MAX_WINDOW) ? MAX_WINDOW : int'(window_reg));
                  space = 2 * win;
                  base_ptr = SEQ_W'(int'(base_ptr) % space);
                  words.push_back(result_word(KIND_ACK, seq, '0, '0));
                  offset = (int'(seq) + space - int'(base_ptr)) % space;
                  if (int'(seq) < space && offset < win) begin
                     shook = 1'b1;
                     slot_full[seq]   = 1'b1;
                     slot_bytes[seq]  = (int'(len) > PAYLOAD_BYTES) ? LEN_W'(PAYLOAD_BYTES)
                                                                   : len;
                     slot_handle[seq] = pref;
                     // in-order drain, at most one window per datagram
                     for (n = 0; n < win && slot_full[base_ptr]; n++) begin
                        words.push_back(result_word(KIND_DELIVER, '0, slot_bytes[base_ptr],
                                                    slot_handle[base_ptr]));
                        slot_full[base_ptr] = 1'b0;
                        base_ptr = (int'(base_ptr) + 1 == space) ? '0 : base_ptr + 1'b1;
                     end
                  end
               end
            end
         endcase
      end
      if (words.size() > 0)
         words[words.size() - 1].last = 1'b1;
      foreach (words[i])
         expected_words.push_back(words[i]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         window_reg = WIN_RESET;
         req_got    = 1'b0;
         shook      = 1'b0;
         fin_got    = 1'b0;
         ended      = 1'b0;
         base_ptr   = '0;
         for (int i = 0; i < SLOTS; i++)
            slot_full[i] = 1'b0;
         expected_words.delete();
         mismatch_count = 0;
      end else begin
         if (pop && !empty) begin
            got_word.kind    = kind_type'(rsp_kind);
            got_word.ack_seq = rsp_ack_seq;
            got_word.out_len = rsp_out_len;
            got_word.out_ref = rsp_out_ref;
            got_word.last    = rsp_last;
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("word kind %0d with nothing expected", rsp_kind));
            end else begin
               want_word = expected_words.pop_front();
               if (got_word.kind !== want_word.kind || got_word.ack_seq !== want_word.ack_seq
                   || got_word.out_len !== want_word.out_len
                   || got_word.out_ref !== want_word.out_ref
                   || got_word.last !== want_word.last)
                  report_mismatch($sformatf("got %0d/%0d/%0d/%h/%b want %0d/%0d/%0d/%h/%b",
                     got_word.kind, got_word.ack_seq, got_word.out_len, got_word.out_ref,
                     got_word.last, want_word.kind, want_word.ack_seq, want_word.out_len,
                     want_word.out_ref, want_word.last));
            end
         end
         if (csr_write_en)
            window_reg = csr_write_data;
         if (push && !full)
            predict_datagram(cmd_type'(req_cmd), req_seq_id, req_payload_len,
                             req_payload_ref);
      end
      words_waiting <= expected_words.size();
   end

endmodule

// ----- sim/selective_repeat_receiver_reorder_test.sv -----
`timescale 1ns / 1ps
// selective_repeat_receiver_reorder_test: drives datagrams, window writes and result
// pops into the receiver; depends on srr_pkg, the receiver RTL and srr_checker

module selective_repeat_receiver_reorder_test;
   import srr_pkg::*;

   localparam int MAX_WINDOW    = 16;
   localparam int PAYLOAD_BYTES = 1024;
   localparam int QUIET_CYCLES  = 60;
   localparam int STALL_LIMIT   = 4000;
   localparam int NUM_PHASES    = 10;
   localparam int PHASE_WORDS   = 16;

   logic             clock           = 1'b0;
   logic             reset           = 1'b1;
   logic             csr_write_en    = 1'b0;
   logic [WIN_W-1:0] csr_write_data  = '0;
   logic             push            = 1'b0;
   logic [1:0]       req_cmd         = CMD_DATA;
   logic [SEQ_W-1:0] req_seq_id      = '0;
   logic [LEN_W-1:0] req_payload_len = '0;
   logic [REF_W-1:0] req_payload_ref = '0;
   logic             pop             = 1'b0;
   logic             full;
   logic             empty;
   logic [2:0]       rsp_kind;
   logic [SEQ_W-1:0] rsp_ack_seq;
   logic [LEN_W-1:0] rsp_out_len;
   logic [REF_W-1:0] rsp_out_ref;
   logic             rsp_last;

   int mismatch_count;
   int words_waiting;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int idle_cycles    = 0;
   int win_eff        = 4;
   int base_guess     = 0;   // where the window base should be, for well-formed bursts
   int window_plan [NUM_PHASES] = '{16, 1, 5, 31, 2, 9, 0, 3, 12, 7};

   selective_repeat_receiver_reorder #(
      .MAX_WINDOW    (MAX_WINDOW),
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .push            (push),
      .full            (full),
      .req_cmd         (req_cmd),
      .req_seq_id      (req_seq_id),
      .req_payload_len (req_payload_len),
      .req_payload_ref (req_payload_ref),
      .empty           (empty),
      .pop             (pop),
      .rsp_kind        (rsp_kind),
      .rsp_ack_seq     (rsp_ack_seq),
      .rsp_out_len     (rsp_out_len),
      .rsp_out_ref     (rsp_out_ref),
      .rsp_last        (rsp_last)
   );

   srr_checker #(
      .MAX_WINDOW    (MAX_WINDOW),
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .push            (push),
      .full            (full),
      .req_cmd         (req_cmd),
      .req_seq_id      (req_seq_id),
      .req_payload_len (req_payload_len),
      .req_payload_ref (req_payload_ref),
      .empty           (empty),
      .pop             (pop),
      .rsp_kind        (rsp_kind),
      .rsp_ack_seq     (rsp_ack_seq),
      .rsp_out_len     (rsp_out_len),
      .rsp_out_ref     (rsp_out_ref),
      .rsp_last        (rsp_last),
      .mismatch_count  (mismatch_count),
      .words_waiting   (words_waiting)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ends the run when nothing moves on either side for too long
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int rand_len();
      return ($urandom_range(4) == 0) ? $urandom_range(2047) : $urandom_range(PAYLOAD_BYTES);
   endfunction

   // push stays high from one word to the next unless a gap is drawn
   task automatic send_word(input cmd_type cmd, input int seq, input int len,
                            input logic [REF_W-1:0] pref);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
      push            <= 1'b1;
      req_cmd         <= cmd;
      req_seq_id      <= seq[SEQ_W-1:0];
      req_payload_len <= len[LEN_W-1:0];
      req_payload_ref <= pref;
      @(posedge clock);
      while (full)
         @(posedge clock);
   endtask

   task automatic send_data(input int seq);
      send_word(CMD_DATA, seq, rand_len(), $urandom);
   endtask

   task automatic wait_quiet();
      push <= 1'b0;
      @(posedge clock);
      while (words_waiting != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input int value);
      csr_write_data <= value[WIN_W-1:0];
      csr_write_en   <= 1'b1;
      @(posedge clock);
      csr_write_en <= 1'b0;
      win_eff    = (value == 0) ? 1 : ((value > MAX_WINDOW) ? MAX_WINDOW : value);
      base_guess = base_guess % (2 * win_eff);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         1: begin
            send_idle_pct = 46;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            recv_stall_pct = 46;
         end
         default: begin
            send_idle_pct = 25;
            recv_stall_pct = 25;
         end
      endcase
   endtask

   // one whole window in shuffled order, with out-of-window repeats and control noise
   task automatic send_burst(inout int sent);
      int order [MAX_WINDOW];
      int space, pick, swap, k, seq;
      space = 2 * win_eff;
      for (k = 0; k < win_eff; k++)
         order[k] = k;
      for (k = win_eff - 1; k > 0; k--) begin
         pick = $urandom_range(k);
         swap = order[k];
         order[k] = order[pick];
         order[pick] = swap;
      end
      for (k = 0; k < win_eff; k++) begin
         if ($urandom_range(99) < 15) begin
            case ($urandom_range(3))
               0: send_word(CMD_REQ, $urandom_range(31), rand_len(), $urandom);
               1: send_word(CMD_CLS, $urandom_range(31), rand_len(), $urandom);
               2: begin
                  // retransmission: either overwrites a waiting slot or lies behind the base
                  seq = (k > 0) ? base_guess + order[$urandom_range(k - 1)]
                                : base_guess + win_eff;
                  send_data(seq % space);
                  sent++;
               end
               default: begin
                  if (space < 32 && $urandom_range(1) == 1)
                     seq = $urandom_range(31, space);
                  else
                     seq = (base_guess + win_eff + $urandom_range(win_eff - 1)) % space;
                  send_data(seq);
                  sent++;
               end
            endcase
         end
         send_data((base_guess + order[k]) % space);
         sent++;
      end
      base_guess = (base_guess + win_eff) % space;
   endtask

   initial begin : stimulus
      int p, k, pick, sent;
      bit held;
      held = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // session setup and its wrong-state commands, window 4 from reset
      send_word(CMD_DATA, 0, 10, 32'h1111_0000);    // before any REQ
      send_word(CMD_FIN, 0, 0, '0);
      send_word(CMD_CLS, 0, 0, '0);
      send_word(CMD_REQ, 0, 0, '0);
      send_word(CMD_REQ, 31, 2047, '1);             // REQ repeated before handshake
      send_word(CMD_FIN, 0, 0, '0);                 // FIN before handshake
      send_data(9);                                 // beyond the sequence space
      send_data(4);                                 // in space, out of window
      send_word(CMD_DATA, 1, 0, '0);
      send_word(CMD_REQ, 0, 0, '0);                 // REQ after handshake
      send_word(CMD_CLS, 0, 0, '0);                 // CLS before FIN
      send_word(CMD_DATA, 3, 2047, '1);             // length saturates
      send_word(CMD_DATA, 3, 1024, 32'h1234_5678);  // overwrite before delivery
      send_word(CMD_DATA, 2, 1025, 32'h8000_0001);
      send_word(CMD_DATA, 0, 1, 32'h0000_0002);     // drains a full window
      send_data(31);
      send_data(7);                                 // left waiting across window changes
      wait_quiet();
      write_window(0);                              // used as a window of one
      send_data(0);                                 // base folds into the new space
      send_data(1);
      send_data(1);
      wait_quiet();
      write_window(31);                             // clipped to the largest window
      send_data(0);
      base_guess = 1;

      for (p = 0; p < NUM_PHASES; p++) begin
         wait_quiet();
         write_window(window_plan[p]);
         set_idling(p % 4);
         sent = 0;
         while (sent < PHASE_WORDS) begin
            send_burst(sent);
            if (p == 3 && !held && sent >= PHASE_WORDS / 2) begin
               held = 1'b1;
               wait_quiet();
            end
         end
      end

      // unshaped traffic over the whole sequence space
      wait_quiet();
      write_window(16);
      set_idling(3);
      for (k = 0; k < 30; k++) begin
         pick = $urandom_range(9);
         send_word(cmd_type'((pick < 7) ? CMD_DATA : ((pick < 9) ? CMD_REQ : CMD_CLS)),
                   $urandom_range(31), rand_len(), $urandom);
      end

      // teardown, then the closed session ignores everything
      send_word(CMD_FIN, 0, 0, '0);
      send_word(cmd_type'($urandom_range(3)), $urandom_range(31), rand_len(), $urandom);
      for (k = 0; k < 4; k++)
         send_word(cmd_type'(k), $urandom_range(31), rand_len(), $urandom);

      wait_quiet();
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
